// ----- hw/rtl/sha256mh_pkg.sv -----
// package for the sha-256 message hasher: state codes, command/status structs,
// round constants, initial hash values and the sigma functions
// no dependencies
package sha256mh_pkg;

  localparam int WordW    = 32;
  localparam int NumWords = 8;
  localparam int SchedLen = 16;

  localparam logic       FUNC_ABSORB   = 1'b0;
  localparam logic       FUNC_FINISH   = 1'b1;
  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [5:0] FILL_LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [6:0] LAST_STEP     = 7'd64;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_INIT,
    ST_RUN,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       push_byte;
    logic [7:0] byte_val;
    logic       count_bits;
    logic       snap_len;
    logic       len_shift;
    logic       load_vars;
    logic       sched_step;
    logic       sched_expand;
    logic       do_round;
    logic [5:0] round_idx;
    logic       add_hash;
    logic       emit_shift;
    logic [2:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [7:0] len_byte;
  } sts_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hw/rtl/sha256_message_hasher_core.sv -----
// sha-256 message hasher, top level: controller plus datapath
// depends on sha256mh_pkg, sha256mh_ctrl, sha256mh_dpath
//
// input channel (in_valid/in_ready): func 0 absorbs data_byte, func 1
// finishes the message. an absorbed byte is taken while idle; the byte that
// completes a 64-byte block holds in_ready low through its compression
// (load, 64 rounds plus one schedule lead-in, hash add), carried out by the
// single round unit at one round per cycle, so no new byte is taken until
// the compression ends.
// a finish request pads one byte per cycle up to the length field (pausing
// for a compression when a block fills), pushes the 8 length bytes, and runs
// one or two compressions, then offers the digest on the output channel
// (out_valid/out_ready) as eight words, word_index 0..7, last_word on word 7.
// digest words come straight from the hash registers; while the receiver
// stalls the block holds the current word and takes no new request. after
// word 7 the hash restarts from the initial values for the next message.
// reset (rst, synchronous) loads the initial hash, clears the byte and
// bit counters and returns to idle.
module sha256_message_hasher_core
  import sha256mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  cmd_t cmd;
  sts_t sts;

  sha256mh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .last_word  (last_word),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha256mh_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (digest_word)
  );

endmodule

// ----- hw/rtl/sha256mh_dpath.sv -----
// datapath: byte packer, rolling message schedule, round variables,
// hash words and length counter; driven by commands from sha256mh_ctrl
// depends on sha256mh_pkg
module sha256mh_dpath
  import sha256mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] digest_word
);

  logic [23:0] acc;
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [63:0] len;
  logic [31:0] sched [SchedLen];
  logic [31:0] w_reg;
  logic [31:0] vars [NumWords];
  logic [31:0] hash [NumWords];

  logic [31:0] packed_word;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign packed_word = {acc, cmd.byte_val};

  // sched[0] is w[t-16], sched[1] w[t-15], sched[9] w[t-7], sched[14] w[t-2]
  assign w_new = cmd.sched_expand
               ? sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14])
               : sched[0];

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + big_sigma1(vars[4]) + ch + ROUND_K[cmd.round_idx] + w_reg;
  assign t2  = big_sigma0(vars[0]) + maj;

  assign sts.fill     = fill;
  assign sts.len_byte = len[63:56];
  assign digest_word  = hash[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      msg_bits <= '0;
      for (int i = 0; i < NumWords; i++) hash[i] <= INIT_HASH[i];
    end else begin
      if (cmd.push_byte) begin
        fill <= fill + 6'd1;
      end
      if (cmd.snap_len) begin
        msg_bits <= '0;
      end else if (cmd.count_bits) begin
        msg_bits <= msg_bits + 64'd8;
      end
      if (cmd.add_hash) begin
        for (int i = 0; i < NumWords; i++) hash[i] <= hash[i] + vars[i];
      end else if (cmd.emit_shift) begin
        // shift the digest out and refill with the initial values behind it
        for (int i = 0; i < NumWords - 1; i++) hash[i] <= hash[i + 1];
        hash[NumWords - 1] <= INIT_HASH[cmd.emit_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_byte) begin
      acc <= packed_word[23:0];
      if (fill[1:0] == 2'b11) begin
        for (int i = 0; i < SchedLen - 1; i++) sched[i] <= sched[i + 1];
        sched[SchedLen - 1] <= packed_word;
      end
    end
    if (cmd.sched_step) begin
      for (int i = 0; i < SchedLen - 1; i++) sched[i] <= sched[i + 1];
      sched[SchedLen - 1] <= w_new;
      w_reg <= w_new;
    end
    if (cmd.snap_len) begin
      len <= msg_bits;
    end else if (cmd.len_shift) begin
      len <= {len[55:0], ZERO_BYTE};
    end
    if (cmd.load_vars) begin
      for (int i = 0; i < NumWords; i++) vars[i] <= hash[i];
    end else if (cmd.do_round) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

// ----- hw/rtl/sha256mh_ctrl.sv -----
// controller: sequences byte absorb, padding, length, compression rounds
// and digest output; drives sha256mh_dpath through cmd_t
// depends on sha256mh_pkg
module sha256mh_ctrl
  import sha256mh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] word_index,
  output logic       last_word,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [6:0] rnd;
  logic [2:0] widx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      rnd   <= '0;
      widx  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (state == ST_INIT) begin
        rnd <= '0;
      end else if (state == ST_RUN) begin
        rnd <= rnd + 7'd1;
      end
      if (state == ST_EMIT && out_ready) begin
        widx <= widx + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ret_next = (func == FUNC_FINISH) ? ST_PAD : ST_IDLE;
          if (sts.fill == FILL_LAST) begin
            state_next = ST_INIT;
          end else if (func == FUNC_FINISH) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        priority if (sts.fill == FILL_LEN_POS) begin
          state_next = ST_LEN;
        end else if (sts.fill == FILL_LAST) begin
          state_next = ST_INIT;
          ret_next   = ST_PAD;
        end
      end
      ST_LEN: begin
        if (sts.fill == FILL_LAST) begin
          state_next = ST_INIT;
          ret_next   = ST_EMIT;
        end
      end
      ST_INIT: state_next = ST_RUN;
      ST_RUN: begin
        if (rnd == LAST_STEP) state_next = ST_ADD;
      end
      ST_ADD: state_next = ret;
      ST_EMIT: begin
        if (out_ready && widx == LAST_WORD_IDX) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push_byte = 1'b1;
          if (func == FUNC_FINISH) begin
            cmd.byte_val = PAD_BYTE;
            cmd.snap_len = 1'b1;
          end else begin
            cmd.byte_val   = data_byte;
            cmd.count_bits = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd.byte_val  = ZERO_BYTE;
        cmd.push_byte = (sts.fill != FILL_LEN_POS);
      end
      ST_LEN: begin
        cmd.byte_val  = sts.len_byte;
        cmd.push_byte = 1'b1;
        cmd.len_shift = 1'b1;
      end
      ST_INIT: cmd.load_vars = 1'b1;
      ST_RUN: begin
        // schedule runs one step ahead of the round that consumes it
        cmd.sched_step   = ~rnd[6];
        cmd.sched_expand = ~rnd[6] && (rnd[5:4] != 2'b00);
        cmd.do_round     = (rnd != 7'd0);
        cmd.round_idx    = 6'(rnd - 7'd1);
      end
      ST_ADD: cmd.add_hash = 1'b1;
      ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.emit_shift = out_ready;
        cmd.emit_idx   = widx;
      end
      default: cmd = '0;
    endcase
  end

  assign word_index = widx;
  assign last_word  = (widx == LAST_WORD_IDX);

endmodule
